// ===== src/snt_pkg.sv =====
`timescale 1ns / 1ps

package snt_pkg;

  localparam logic [2:0] CMD_UPSERT = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_NEXT   = 3'd2;
  localparam logic [2:0] CMD_PREV   = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] time_stamp;
    logic [31:0] seq;
    logic [7:0]  flags;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SHIFT,
    OP_SORT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     target;
    logic     below_i;
    logic     last;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SORT,
    ST_FIX
  } state_t;

  // Known distinct times decide; otherwise the arrival sequence does.
  function automatic logic newer(input logic [31:0] ta, input logic [31:0] sa,
                                 input logic [31:0] tb, input logic [31:0] sb);
    logic r;
    if (ta != 32'd0 && tb != 32'd0 && ta != tb) begin
      r = (ta > tb);
    end else begin
      r = (sa > sb);
    end
    return r;
  endfunction

endpackage

// ===== src/snt_if.sv =====
`timescale 1ns / 1ps

interface snt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] entry_key;
  logic [31:0] entry_time;
  logic [7:0]  entry_flags;

  modport source (output valid, cmd, entry_key, entry_time, entry_flags, input ready);
  modport sink (input valid, cmd, entry_key, entry_time, entry_flags, output ready);
endinterface

interface snt_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  entry_count;
  logic [3:0]  selected_pos;
  logic [31:0] selected_key;
  logic [7:0]  selected_flags;
  logic        was_new;

  modport source (output valid, entry_count, selected_pos, selected_key, selected_flags,
                  was_new, input ready);
  modport sink (input valid, entry_count, selected_pos, selected_key, selected_flags,
                was_new, output ready);
endinterface

// ===== src/snt_cell.sv =====
`timescale 1ns / 1ps

module snt_cell (
  input  logic               clk,
  input  snt_pkg::cell_ctrl_t ctrl,
  input  snt_pkg::entry_t    wr,
  input  snt_pkg::entry_t    x,
  input  snt_pkg::entry_t    left,
  input  snt_pkg::entry_t    right,
  input  logic [31:0]        probe_key,
  input  logic               run_right,
  input  logic               run_left,
  output snt_pkg::entry_t    ent,
  output logic               run,
  output logic               match
);

  logic cmp;

  assign cmp   = snt_pkg::newer(x.time_stamp, x.seq, ent.time_stamp, ent.seq);
  // The candidate passes this cell only if it also passed every cell to the right.
  assign run   = ctrl.below_i && cmp && (ctrl.last || run_right);
  assign match = (ent.key == probe_key);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      snt_pkg::OP_LOAD: begin
        if (ctrl.target) ent <= wr;
      end
      snt_pkg::OP_SHIFT: begin
        if (ctrl.target) ent <= right;
      end
      snt_pkg::OP_SORT: begin
        if (run_left) begin
          ent <= left;
        end else if (run) begin
          ent <= x;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/sorted_notification_table_top.sv =====
`timescale 1ns / 1ps
// An upsert passes from ST_EXEC through ST_SORT (one sort step per held entry after the
// first, in the cell chain) to ST_FIX, which registers the result; other commands go
// straight from ST_EXEC to ST_FIX. One transaction at a time: a new request is taken
// only after the result is registered, and ST_FIX waits while the last one is untaken.
// Reset (synchronous, active high) empties the table, drops the selection,
// zeroes the sequence counter and clears the pending result.

module sorted_notification_table_top #(
  parameter int MAX_ENTRIES = 8
) (
  input logic clk,
  input logic rst,
  snt_req_if.sink   req,
  snt_rsp_if.source rsp
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

  snt_pkg::state_t state, state_next;

  logic [2:0]  lcmd;
  logic [31:0] lkey, ltime;
  logic [7:0]  lflags;

  logic [CW-1:0] count, sel_pos, sort_i;
  logic [31:0]   seq_ctr, sel_key;
  logic          fix_pos_mode;
  logic [IW-1:0] fix_idx;
  logic          was_new;
  logic          out_valid;

  snt_pkg::entry_t ent [MAX_ENTRIES];
  snt_pkg::cell_ctrl_t cctl [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] run, match, hit;

  snt_pkg::cell_op_t op;
  snt_pkg::entry_t wr, x, hit_ent, fix_ent;
  logic [31:0]   probe, fresh_seq;
  logic          hit_any, full;
  logic [IW-1:0] hit_idx, ld_idx;
  logic          is_up, is_rm, is_step, is_clr;
  logic [CW-1:0] cnt_after, rm_pos, cur0, cur;
  logic [CW-1:0] fix_pos;
  logic [31:0]   fix_key;
  logic [7:0]    fix_flags;

  assign req.ready = (state == snt_pkg::ST_IDLE);
  assign rsp.valid = out_valid;

  assign probe = (state == snt_pkg::ST_FIX) ? sel_key : lkey;

  always_comb begin
    hit_idx = '0;
    for (int m = MAX_ENTRIES - 1; m >= 0; m--) begin
      hit[m] = match[m] && (CW'(m) < count);
      if (hit[m]) hit_idx = IW'(m);
    end
    hit_any = |hit;
  end

  assign hit_ent   = ent[hit_idx];
  assign x         = ent[sort_i[IW-1:0]];
  assign fix_ent   = ent[fix_idx];
  assign full      = (count == MAX_C);
  assign fresh_seq = seq_ctr + 32'd1;

  assign is_up   = (lcmd == snt_pkg::CMD_UPSERT) && (lkey != 32'd0);
  assign is_rm   = (lcmd == snt_pkg::CMD_REMOVE) && (lkey != 32'd0) && hit_any;
  assign is_step = ((lcmd == snt_pkg::CMD_NEXT) || (lcmd == snt_pkg::CMD_PREV)) &&
                   (count > CW'(1));
  assign is_clr  = (lcmd == snt_pkg::CMD_CLEAR);

  always_comb begin
    if (hit_any) begin
      ld_idx = hit_idx;
    end else if (full) begin
      ld_idx = IW'(MAX_ENTRIES - 1);
    end else begin
      ld_idx = count[IW-1:0];
    end
    wr.key        = lkey;
    wr.time_stamp = ltime;
    wr.flags      = lflags;
    wr.seq        = (hit_any && hit_ent.seq != 32'd0) ? hit_ent.seq : fresh_seq;
  end

  always_comb begin
    cnt_after = count - CW'(1);
    rm_pos    = (CW'(hit_idx) >= cnt_after) ? cnt_after - CW'(1) : CW'(hit_idx);
    cur0      = (sel_pos != '0) ? sel_pos - CW'(1) : '0;
    if (lcmd == snt_pkg::CMD_PREV) begin
      cur = (cur0 == '0) ? count - CW'(1) : cur0 - CW'(1);
    end else begin
      cur = (cur0 + CW'(1) >= count) ? '0 : cur0 + CW'(1);
    end
  end

  always_comb begin
    fix_pos   = '0;
    fix_key   = '0;
    fix_flags = '0;
    if (fix_pos_mode) begin
      fix_pos   = CW'(fix_idx) + CW'(1);
      fix_key   = fix_ent.key;
      fix_flags = fix_ent.flags;
    end else if (hit_any) begin
      fix_pos   = CW'(hit_idx) + CW'(1);
      fix_key   = sel_key;
      fix_flags = hit_ent.flags;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      snt_pkg::ST_IDLE: if (req.valid) state_next = snt_pkg::ST_EXEC;
      snt_pkg::ST_EXEC: state_next = is_up ? snt_pkg::ST_SORT : snt_pkg::ST_FIX;
      snt_pkg::ST_SORT: if (sort_i >= count) state_next = snt_pkg::ST_FIX;
      snt_pkg::ST_FIX:  if (!out_valid || rsp.ready) state_next = snt_pkg::ST_IDLE;
      default:          state_next = snt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op = snt_pkg::OP_HOLD;
    unique case (state)
      snt_pkg::ST_EXEC: begin
        if (is_up) begin
          op = snt_pkg::OP_LOAD;
        end else if (is_rm) begin
          op = snt_pkg::OP_SHIFT;
        end
      end
      snt_pkg::ST_SORT: if (sort_i < count) op = snt_pkg::OP_SORT;
      default: op = snt_pkg::OP_HOLD;
    endcase
  end

  for (genvar m = 0; m < MAX_ENTRIES; m++) begin : g_cell
    snt_pkg::entry_t left_ent, right_ent;
    logic run_l, run_r;

    assign cctl[m].op      = op;
    assign cctl[m].target  = (op == snt_pkg::OP_LOAD) ? (IW'(m) == ld_idx)
                                                      : (IW'(m) >= hit_idx);
    assign cctl[m].below_i = (CW'(m) < sort_i);
    assign cctl[m].last    = (CW'(m + 1) == sort_i);

    if (m == 0) begin : g_first
      assign left_ent = '0;
      assign run_l    = 1'b0;
    end else begin : g_mid_l
      assign left_ent = ent[m-1];
      assign run_l    = run[m-1];
    end

    if (m == MAX_ENTRIES - 1) begin : g_last
      assign right_ent = '0;
      assign run_r     = 1'b0;
    end else begin : g_mid_r
      assign right_ent = ent[m+1];
      assign run_r     = run[m+1];
    end

    snt_cell u_cell (
      .clk       (clk),
      .ctrl      (cctl[m]),
      .wr        (wr),
      .x         (x),
      .left      (left_ent),
      .right     (right_ent),
      .probe_key (probe),
      .run_right (run_r),
      .run_left  (run_l),
      .ent       (ent[m]),
      .run       (run[m]),
      .match     (match[m])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= snt_pkg::ST_IDLE;
      count     <= '0;
      seq_ctr   <= '0;
      sel_pos   <= '0;
      sel_key   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (req.valid && req.ready) begin
        lcmd   <= req.cmd;
        lkey   <= req.entry_key;
        ltime  <= req.entry_time;
        lflags <= req.entry_flags;
      end
      // In ST_FIX the result register is reloaded below instead.
      if (out_valid && rsp.ready && state != snt_pkg::ST_FIX) out_valid <= 1'b0;

      case (state)
        snt_pkg::ST_EXEC: begin
          was_new      <= 1'b0;
          fix_pos_mode <= 1'b0;
          sort_i       <= CW'(1);
          if (is_up) begin
            if (hit_any) begin
              if (hit_ent.seq == 32'd0) seq_ctr <= fresh_seq;
            end else begin
              seq_ctr <= fresh_seq;
              sel_key <= lkey;
              was_new <= 1'b1;
              if (!full) count <= count + CW'(1);
            end
          end else if (is_rm) begin
            count <= cnt_after;
            if (cnt_after == '0) begin
              sel_key <= '0;
            end else if (sel_key == lkey) begin
              fix_pos_mode <= 1'b1;
              fix_idx      <= rm_pos[IW-1:0];
            end
          end else if (is_step) begin
            fix_pos_mode <= 1'b1;
            fix_idx      <= cur[IW-1:0];
          end else if (is_clr) begin
            count   <= '0;
            sel_key <= '0;
          end
        end
        snt_pkg::ST_SORT: begin
          if (sort_i < count) sort_i <= sort_i + CW'(1);
        end
        snt_pkg::ST_FIX: begin
          if (!out_valid || rsp.ready) begin
            out_valid          <= 1'b1;
            sel_pos            <= fix_pos;
            if (fix_pos_mode) sel_key <= fix_key;
            rsp.entry_count    <= 4'(count);
            rsp.selected_pos   <= 4'(fix_pos);
            rsp.selected_key   <= fix_key;
            rsp.selected_flags <= fix_flags;
            rsp.was_new        <= was_new;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/snt_checker.sv =====
`timescale 1ns / 1ps

module snt_checker #(
  parameter int MAX_ENTRIES = 8
) (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [3:0]  entry_count,
  input logic [3:0]  selected_pos,
  input logic [31:0] selected_key,
  input logic [7:0]  selected_flags,
  input logic        was_new
);

  localparam logic NARROW = (MAX_ENTRIES < 16);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(selected_key))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("new transaction taken while one is in work");

  a_no_sel_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && selected_pos == 4'd0 |-> selected_key == 32'd0 && selected_flags == 8'd0)
    else $error("empty selection carries data");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && NARROW |-> selected_pos <= entry_count)
    else $error("selection beyond held entries");

  a_new_selected: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && was_new && NARROW |-> selected_pos != 4'd0 && selected_key != 32'd0)
    else $error("inserted key not selected");

endmodule

bind sorted_notification_table_top snt_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_snt_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .entry_count    (rsp.entry_count),
  .selected_pos   (rsp.selected_pos),
  .selected_key   (rsp.selected_key),
  .selected_flags (rsp.selected_flags),
  .was_new        (rsp.was_new)
);

// ===== sim/snt_checker.sv =====
`timescale 1ns / 1ps

module snt_scoreboard #(
  parameter int MAX_ENTRIES = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  logic [2:0]  cmd,
  input  logic [31:0] entry_key,
  input  logic [31:0] entry_time,
  input  logic [7:0]  entry_flags,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  logic [3:0]  entry_count,
  input  logic [3:0]  selected_pos,
  input  logic [31:0] selected_key,
  input  logic [7:0]  selected_flags,
  input  logic was_new,
  output int   fail_count,
  output int   pending,
  output int   status_seen,
  output int   inserts_seen
);

  typedef struct packed {
    logic [3:0]  count;
    logic [3:0]  pos;
    logic [31:0] key;
    logic [7:0]  flags;
    logic        fresh;
  } status_t;

  snt_pkg::entry_t tbl [MAX_ENTRIES];
  int unsigned held;
  logic [31:0] seq_ctr;
  int unsigned sel_pos;
  logic [31:0] sel_k;
  status_t     status_q[$];

  function automatic bit is_later(snt_pkg::entry_t a, snt_pkg::entry_t b);
    if (a.time_stamp != 0 && b.time_stamp != 0 && a.time_stamp != b.time_stamp) begin
      return a.time_stamp > b.time_stamp;
    end
    return a.seq > b.seq;
  endfunction

  function automatic void reorder();
    snt_pkg::entry_t e;
    int j;
    for (int i = 1; i < held; i++) begin
      e = tbl[i];
      j = i;
      while (j > 0 && is_later(e, tbl[j-1])) begin
        tbl[j] = tbl[j-1];
        j--;
      end
      tbl[j] = e;
    end
  endfunction

  function automatic int locate(logic [31:0] k);
    for (int i = 0; i < held; i++) begin
      if (tbl[i].key == k) return i;
    end
    return MAX_ENTRIES;
  endfunction

  function automatic void pick(int idx);
    if (held == 0 || idx >= held) begin
      sel_k = 0;
      sel_pos = 0;
    end else begin
      sel_pos = idx + 1;
      sel_k = tbl[idx].key;
    end
  endfunction

  function automatic void track_sel();
    int idx;
    idx = locate(sel_k);
    sel_pos = (idx < held) ? idx + 1 : 0;
  endfunction

  function automatic status_t apply_cmd(logic [2:0] c, logic [31:0] k, logic [31:0] t,
                                        logic [7:0] f);
    status_t s;
    int idx;
    int cur;
    s = '0;
    if (c == snt_pkg::CMD_UPSERT && k != 0) begin
      idx = locate(k);
      if (idx < held) begin
        tbl[idx].time_stamp = t;
        tbl[idx].flags = f;
        if (tbl[idx].seq == 0) begin
          seq_ctr++;
          tbl[idx].seq = seq_ctr;
        end
        reorder();
        if (sel_k != 0) track_sel();
      end else begin
        if (held >= MAX_ENTRIES) idx = held - 1;
        else begin
          idx = held;
          held++;
        end
        seq_ctr++;
        tbl[idx] = '{key: k, time_stamp: t, seq: seq_ctr, flags: f};
        reorder();
        pick(locate(k));
        s.fresh = 1'b1;
      end
    end else if (c == snt_pkg::CMD_REMOVE && k != 0) begin
      idx = locate(k);
      if (idx < held) begin
        for (int i = idx + 1; i < held; i++) tbl[i-1] = tbl[i];
        held--;
        if (held == 0) pick(0);
        else if (sel_k == k) pick(idx >= held ? held - 1 : idx);
        else track_sel();
      end
    end else if (c == snt_pkg::CMD_NEXT || c == snt_pkg::CMD_PREV) begin
      if (held > 1) begin
        cur = sel_pos > 0 ? sel_pos - 1 : 0;
        if (c == snt_pkg::CMD_PREV) cur = (cur == 0) ? held - 1 : cur - 1;
        else cur = (cur + 1 >= held) ? 0 : cur + 1;
        pick(cur);
      end
    end else if (c == snt_pkg::CMD_CLEAR) begin
      held = 0;
      pick(0);
    end
    s.count = held[3:0];
    if (sel_pos > 0 && sel_pos <= held) begin
      s.pos = sel_pos[3:0];
      s.key = tbl[sel_pos-1].key;
      s.flags = tbl[sel_pos-1].flags;
    end
    return s;
  endfunction

  assign pending = status_q.size();

  always @(posedge clk) begin
    status_t exp_s;
    if (rst) begin
      held = 0;
      seq_ctr = 0;
      sel_pos = 0;
      sel_k = 0;
      status_q.delete();
      fail_count <= 0;
      status_seen <= 0;
      inserts_seen <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        status_seen <= status_seen + 1;
        if (status_q.size() == 0) begin
          $error("status with no command outstanding");
          fail_count <= fail_count + 1;
        end else begin
          exp_s = status_q.pop_front();
          if (exp_s.fresh) inserts_seen <= inserts_seen + 1;
          if (entry_count !== exp_s.count || selected_pos !== exp_s.pos ||
              selected_key !== exp_s.key || selected_flags !== exp_s.flags ||
              was_new !== exp_s.fresh) begin
            fail_count <= fail_count + 1;
            if (entry_count !== exp_s.count)
              $error("entry_count exp %0d got %0d", exp_s.count, entry_count);
            if (selected_pos !== exp_s.pos)
              $error("selected_pos exp %0d got %0d", exp_s.pos, selected_pos);
            if (selected_key !== exp_s.key)
              $error("selected_key exp %h got %h", exp_s.key, selected_key);
            if (selected_flags !== exp_s.flags)
              $error("selected_flags exp %h got %h", exp_s.flags, selected_flags);
            if (was_new !== exp_s.fresh)
              $error("was_new exp %0d got %0d", exp_s.fresh, was_new);
          end
        end
      end
      if (req_valid && req_ready)
        status_q.push_back(apply_cmd(cmd, entry_key, entry_time, entry_flags));
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int NUM_RANDOM = 1030;
  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst;
  int   fail_count, pending, status_seen, inserts_seen;
  int   idle_cycles;
  bit   long_hold;
  bit   done;

  snt_req_if req ();
  snt_rsp_if rsp ();

  sorted_notification_table_top #(.MAX_ENTRIES(8)) DUT (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp)
  );

  snt_scoreboard #(.MAX_ENTRIES(8)) u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req.valid), .req_ready(req.ready), .cmd(req.cmd),
    .entry_key(req.entry_key), .entry_time(req.entry_time), .entry_flags(req.entry_flags),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .entry_count(rsp.entry_count),
    .selected_pos(rsp.selected_pos), .selected_key(rsp.selected_key),
    .selected_flags(rsp.selected_flags), .was_new(rsp.was_new),
    .fail_count(fail_count), .pending(pending), .status_seen(status_seen),
    .inserts_seen(inserts_seen)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Keys from a small pool so upserts and removes hit held entries.
  function automatic logic [31:0] pool_key();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      2: return 32'd0;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom();
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  task automatic send(logic [2:0] c, logic [31:0] k, logic [31:0] t, logic [7:0] f);
    req.valid <= 1'b1;
    req.cmd <= c;
    req.entry_key <= k;
    req.entry_time <= t;
    req.entry_flags <= f;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    req.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Receiver stalls: a long hold when requested, otherwise a random pattern.
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (long_hold) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    long_hold = 1'b0;
    repeat (200) @(negedge clk);
    long_hold = 1'b1;
    repeat (150) @(negedge clk);
    long_hold = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int burst;
    int r;
    done = 1'b0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.cmd = snt_pkg::CMD_UPSERT;
    req.entry_key = '0;
    req.entry_time = '0;
    req.entry_flags = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed: empty stepping, zero keys, fill past capacity, zero times, removals.
    send(snt_pkg::CMD_NEXT, 0, 0, 0);
    send(snt_pkg::CMD_UPSERT, 32'd0, 32'd5, 8'hFF);
    send(snt_pkg::CMD_REMOVE, 32'd7, 0, 0);
    for (int i = 1; i <= 9; i++)
      send(snt_pkg::CMD_UPSERT, i, (i % 3 == 0) ? 0 : 10 - i, i[7:0]);
    send(snt_pkg::CMD_UPSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hA5);
    send(snt_pkg::CMD_UPSERT, 32'd4, 32'd4, 8'h5A);
    send(snt_pkg::CMD_PREV, 0, 0, 0);
    send(snt_pkg::CMD_NEXT, 0, 0, 0);
    send(snt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 0, 0);
    send(snt_pkg::CMD_REMOVE, 32'd0, 0, 0);
    send(3'd5, 32'd1, 0, 0);
    send(3'd7, 32'd2, 0, 0);
    send(snt_pkg::CMD_CLEAR, 0, 0, 0);
    send(snt_pkg::CMD_REMOVE, 32'd2, 0, 0);
    send(snt_pkg::CMD_UPSERT, 32'd2, 32'd0, 8'h00);
    send(snt_pkg::CMD_NEXT, 0, 0, 0);
    drain();

    for (int n = 0; n < NUM_RANDOM; ) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && n < NUM_RANDOM; b++, n++) begin
        r = $urandom_range(0, 99);
        if (r < 50)
          send(snt_pkg::CMD_UPSERT, pool_key(), pick_time(), 8'($urandom()));
        else if (r < 70)
          send(snt_pkg::CMD_REMOVE, pool_key(), $urandom(), 8'($urandom()));
        else if (r < 82)
          send(snt_pkg::CMD_NEXT, $urandom(), $urandom(), 8'($urandom()));
        else if (r < 94)
          send(snt_pkg::CMD_PREV, $urandom(), $urandom(), 8'($urandom()));
        else if (r < 97)
          send(snt_pkg::CMD_CLEAR, $urandom(), $urandom(), 8'($urandom()));
        else
          send(3'($urandom_range(5, 7)), pool_key(), $urandom(), 8'($urandom()));
      end
      if (n == NUM_RANDOM / 2) drain();
      else if ($urandom_range(0, 2) != 0) pause_sender();
    end
    drain();
    done = 1'b1;
    repeat (20) @(negedge clk);

    $display("Covered %0d commands with %0d statuses, %0d new-key inserts.",
             NUM_RANDOM + 24, status_seen, inserts_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/snt_pkg.sv
src/snt_if.sv
src/snt_cell.sv
src/sorted_notification_table_top.sv
src/snt_checker.sv
sim/snt_checker.sv
sim/tb.sv
